// ===== hdl/u2mfcc_pkg.sv =====
package u2mfcc_pkg;

   localparam int CODE_CHARS_DEF = 4;
   localparam int BYTE_W         = 8;
   localparam int CODE_W         = 32;
   localparam int POINT_W        = 16;
   localparam int PEND_W         = 2;
   localparam int MR_TABLE_DEPTH = 128;
   localparam int MR_INDEX_W     = $clog2(MR_TABLE_DEPTH);

   localparam logic [POINT_W-1:0] ASCII_LIMIT = 16'h0080;

   localparam logic [1:0] CONT_TAG  = 2'b10;
   localparam logic [2:0] LEAD2_TAG = 3'b110;
   localparam logic [3:0] LEAD3_TAG = 4'b1110;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   localparam logic [POINT_W-1:0] MR_HIGH_TABLE [MR_TABLE_DEPTH] = '{
      16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
      16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
      16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
      16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
      16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
      16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
      16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
      16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
      16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
      16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
      16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
      16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
      16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
      16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
      16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
      16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
   };

   typedef struct packed {
      logic                  hit;
      logic [MR_INDEX_W-1:0] index;
   } lookup_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] type_code;
      logic              status;
   } result_type;

endpackage

// ===== hdl/u2mfcc_lookup.sv =====
module u2mfcc_lookup
   import u2mfcc_pkg::*;
(
   input  logic [POINT_W-1:0] point,
   output lookup_type         match
);

   always_comb begin
      match = '0;
      // scan downward so the lowest matching index wins
      for (int k = MR_TABLE_DEPTH - 1; k >= 0; k--) begin
         if (MR_HIGH_TABLE[k] == point) begin
            match.hit   = 1'b1;
            match.index = MR_INDEX_W'(k);
         end
      end
   end

endmodule

// ===== hdl/u2mfcc_step.sv =====
module u2mfcc_step
   import u2mfcc_pkg::*;
#(
   parameter int CODE_CHARS = CODE_CHARS_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              item_fire,
   input  logic [BYTE_W-1:0] item_byte,
   input  logic              item_end,
   output result_type        result
);

   localparam int CHARS_W = $clog2(CODE_CHARS + 1);
   localparam logic [CHARS_W-1:0] CHARS_FULL = CHARS_W'(CODE_CHARS);

   logic [PEND_W-1:0]  pend_ff, pend_in;
   logic [POINT_W-1:0] partial_ff, partial_in;
   logic [CHARS_W-1:0] chars_ff, chars_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic               error_ff, error_in;
   logic               term_ff, term_in;

   logic [POINT_W-1:0] partial_next;
   logic [POINT_W-1:0] emit_point;
   logic [BYTE_W-1:0]  emit_byte;
   logic               emit;
   logic               ok;
   lookup_type         match;

   assign partial_next = {partial_ff[POINT_W-7:0], item_byte[5:0]};
   assign emit_point   = (pend_ff != '0) ? partial_next : {{(POINT_W-BYTE_W){1'b0}}, item_byte};

   u2mfcc_lookup u_lookup (
      .point (emit_point),
      .match (match)
   );

   assign emit_byte = (emit_point < ASCII_LIMIT) ? emit_point[BYTE_W-1:0]
                                                 : {1'b1, match.index};

   always_comb begin
      pend_in    = pend_ff;
      partial_in = partial_ff;
      chars_in   = chars_ff;
      code_in    = code_ff;
      error_in   = error_ff;
      term_in    = term_ff;
      emit       = 1'b0;
      ok         = !error_ff && (pend_ff == '0) && (chars_ff == CHARS_FULL);
      result     = '0;

      if (item_fire) begin
         if (item_end) begin
            result.valid     = 1'b1;
            result.type_code = ok ? code_ff : '0;
            result.status    = ok ? STATUS_OK : STATUS_INVALID;
            pend_in    = '0;
            partial_in = '0;
            chars_in   = '0;
            code_in    = '0;
            error_in   = 1'b0;
            term_in    = 1'b0;
         end else if (!error_ff && !term_ff) begin
            if (pend_ff != '0) begin
               if (item_byte[7:6] != CONT_TAG) begin
                  error_in = 1'b1;
               end else begin
                  partial_in = partial_next;
                  pend_in    = pend_ff - 1'b1;
                  emit       = (pend_ff == PEND_W'(1));
               end
            end else if (item_byte == '0) begin
               term_in = 1'b1;
            end else if (chars_ff >= CHARS_FULL) begin
               error_in = 1'b1;
            end else if (!item_byte[7]) begin
               emit = 1'b1;
            end else if (item_byte[7:5] == LEAD2_TAG) begin
               partial_in = {{(POINT_W-5){1'b0}}, item_byte[4:0]};
               pend_in    = PEND_W'(1);
            end else if (item_byte[7:4] == LEAD3_TAG) begin
               partial_in = {{(POINT_W-4){1'b0}}, item_byte[3:0]};
               pend_in    = PEND_W'(2);
            end else begin
               error_in = 1'b1;
            end
         end
      end

      if (emit) begin
         if ((emit_point < ASCII_LIMIT) || match.hit) begin
            code_in  = {code_ff[CODE_W-BYTE_W-1:0], emit_byte};
            chars_in = chars_ff + 1'b1;
         end else begin
            error_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= '0;
         partial_ff <= '0;
         chars_ff   <= '0;
         code_ff    <= '0;
         error_ff   <= 1'b0;
         term_ff    <= 1'b0;
      end else begin
         pend_ff    <= pend_in;
         partial_ff <= partial_in;
         chars_ff   <= chars_in;
         code_ff    <= code_in;
         error_ff   <= error_in;
         term_ff    <= term_in;
      end
   end

endmodule

// ===== hdl/utf8_to_macroman_fourcc.sv =====
// An accepted end beat passes the input register, then the result register, to rsp.
// Throughput: 1 beat per cycle unless an end beat waits on a held result beat;
// the decode step and 128-entry compare network sit between the two registers.
// Reset: synchronous, active high; clears the decoder state and both
// valid registers, so no result is pending after reset.
module utf8_to_macroman_fourcc
   import u2mfcc_pkg::*;
#(
   parameter int CODE_CHARS = CODE_CHARS_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_text_byte,
   input  logic              req_end_of_text,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CODE_W-1:0] rsp_type_code,
   output logic              rsp_status
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              in_end_ff, in_end_in;
   logic              out_valid_ff, out_valid_in;
   logic [CODE_W-1:0] out_code_ff, out_code_in;
   logic              out_status_ff, out_status_in;

   logic       out_free;
   logic       consume;
   logic       accept;
   result_type result;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign consume   = in_valid_ff && (!in_end_ff || out_free);
   assign req_stall = in_valid_ff && !consume;
   assign accept    = req_valid && !req_stall;

   u2mfcc_step #(
      .CODE_CHARS (CODE_CHARS)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .item_fire (consume),
      .item_byte (in_byte_ff),
      .item_end  (in_end_ff),
      .result    (result)
   );

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      in_end_in     = in_end_ff;
      out_valid_in  = out_valid_ff;
      out_code_in   = out_code_ff;
      out_status_in = out_status_ff;

      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_text_byte;
         in_end_in   = req_end_of_text;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end

      // hold the result beat while the far side stalls
      if (out_free) begin
         out_valid_in  = result.valid;
         out_code_in   = result.type_code;
         out_status_in = result.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff    <= in_byte_in;
      in_end_ff     <= in_end_in;
      out_code_ff   <= out_code_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_type_code = out_code_ff;
   assign rsp_status    = out_status_ff;

endmodule

// ===== hdl/u2mfcc_checker.sv =====
module u2mfcc_checker
   import u2mfcc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [CODE_W-1:0] rsp_type_code,
   input logic              rsp_status
);

   a_invalid_zero_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_INVALID) |-> rsp_type_code == '0)
      else $error("invalid result beat carries a nonzero code");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_type_code) && $stable(rsp_status))
      else $error("stalled result beat changed or dropped");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while the result side is free");

   a_reset_empty : assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("result or stall present right after reset");

endmodule

bind utf8_to_macroman_fourcc u2mfcc_checker u_checker (.*);

// ===== test/utf8_to_macroman_fourcc_tb.sv =====
`timescale 1ns / 1ps

module utf8_to_macroman_fourcc_tb;
   import u2mfcc_pkg::*;

   localparam int NCHARS       = CODE_CHARS_DEF;
   localparam int RANDOM_BEATS = 1600;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_AFTER   = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_PRINTS   = 40;

   localparam logic [15:0] MACROMAN_HIGH [128] = '{
      16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
      16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
      16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
      16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
      16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
      16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
      16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
      16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
      16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
      16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
      16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
      16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
      16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
      16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
      16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
      16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
   };

   typedef struct {
      logic [BYTE_W-1:0] text_byte;
      logic              end_of_text;
   } utf8_beat_type;

   typedef struct {
      logic [CODE_W-1:0] type_code;
      logic              status;
   } fourcc_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_text_byte = '0;
   logic              req_end_of_text = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [CODE_W-1:0] rsp_type_code;
   logic              rsp_status;

   utf8_beat_type utf8_beats[$];
   utf8_beat_type next_beat;
   fourcc_type    fourcc_expected[$];
   fourcc_type    fourcc_seen;

   int   total_beats;
   int   beats_accepted = 0;
   int   mismatches = 0;
   int   cycles = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;
   logic req_taken = 1'b0;
   logic quiet;

   logic [1:0]  mr_pend;
   logic [15:0] mr_point;
   int          mr_count;
   logic [31:0] mr_code;
   bit          mr_error;
   bit          mr_ended;

   utf8_to_macroman_fourcc dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_type_code   (rsp_type_code),
      .rsp_status      (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assign quiet = (cycles % 2048) < 256;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < MAX_PRINTS)
         $display("%0t: %s got %h want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic clear_decoder();
      mr_pend  = '0;
      mr_point = '0;
      mr_count = 0;
      mr_code  = '0;
      mr_error = 1'b0;
      mr_ended = 1'b0;
   endtask

   task automatic append_macroman(input logic [15:0] point);
      logic [7:0] mr;
      bit         hit;
      hit = 1'b0;
      mr  = '0;
      if (point < 16'h0080) begin
         mr  = point[7:0];
         hit = 1'b1;
      end else begin
         for (int k = 0; k < 128; k++) begin
            if (!hit && MACROMAN_HIGH[k] == point) begin
               mr  = 8'h80 + k[7:0];
               hit = 1'b1;
            end
         end
      end
      if (!hit) begin
         mr_error = 1'b1;
         return;
      end
      mr_code  = {mr_code[23:0], mr};
      mr_count = mr_count + 1;
   endtask

   task automatic decode_utf8_beat(input logic [7:0] b, input logic eot);
      fourcc_type f;
      if (eot) begin
         if (!mr_error && mr_pend == 0 && mr_count == NCHARS) begin
            f.type_code = mr_code;
            f.status    = STATUS_OK;
         end else begin
            f.type_code = '0;
            f.status    = STATUS_INVALID;
         end
         fourcc_expected.push_back(f);
         clear_decoder();
         return;
      end
      if (mr_error || mr_ended) return;
      if (mr_pend != 0) begin
         if (b[7:6] != CONT_TAG) begin
            mr_error = 1'b1;
            return;
         end
         mr_point = {mr_point[9:0], b[5:0]};
         mr_pend  = mr_pend - 2'd1;
         if (mr_pend == 0) append_macroman(mr_point);
         return;
      end
      if (b == 8'h00) begin
         mr_ended = 1'b1;
      end else if (mr_count >= NCHARS) begin
         mr_error = 1'b1;
      end else if (b[7] == 1'b0) begin
         append_macroman({8'h00, b});
      end else if (b[7:5] == LEAD2_TAG) begin
         mr_point = {11'h000, b[4:0]};
         mr_pend  = 2'd1;
      end else if (b[7:4] == LEAD3_TAG) begin
         mr_point = {12'h000, b[3:0]};
         mr_pend  = 2'd2;
      end else begin
         mr_error = 1'b1;
      end
   endtask

   task automatic push_byte(input logic [7:0] b);
      utf8_beat_type t;
      t.text_byte   = b;
      t.end_of_text = 1'b0;
      utf8_beats.push_back(t);
   endtask

   task automatic push_end(input logic [7:0] b);
      utf8_beat_type t;
      t.text_byte   = b;
      t.end_of_text = 1'b1;
      utf8_beats.push_back(t);
   endtask

   function automatic logic [15:0] pick_point();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 16'h0000;
      if (r < 45) return 16'($urandom_range(1, 127));
      if (r < 92) return MACROMAN_HIGH[$urandom_range(0, 127)];
      return 16'($urandom_range(128, 65535));
   endfunction

   // overlong forms are legal here, so pick the length at random where it fits
   task automatic put_char(input logic [15:0] point, input bit mangle);
      logic [7:0] enc[3];
      int         len;
      if (point != 0 && point < 16'h0080 && $urandom_range(0, 9) < 8) len = 1;
      else if (point < 16'h0800 && $urandom_range(0, 3) != 0) len = 2;
      else len = 3;
      if (len == 1) begin
         enc[0] = point[7:0];
      end else if (len == 2) begin
         enc[0] = {LEAD2_TAG, point[10:6]};
         enc[1] = {CONT_TAG, point[5:0]};
      end else begin
         enc[0] = {LEAD3_TAG, point[15:12]};
         enc[1] = {CONT_TAG, point[11:6]};
         enc[2] = {CONT_TAG, point[5:0]};
      end
      if (mangle && len > 1) enc[len-1] = 8'($urandom_range(0, 255));
      for (int k = 0; k < len; k++) push_byte(enc[k]);
   endtask

   task automatic add_random_text();
      int flavor;
      int nchars;
      flavor = $urandom_range(0, 99);
      nchars = (flavor < 70) ? NCHARS : $urandom_range(0, NCHARS + 2);
      for (int i = 0; i < nchars; i++) begin
         put_char(pick_point(), flavor >= 90 && $urandom_range(0, 3) == 0);
         if (flavor >= 85 && $urandom_range(0, 5) == 0) push_byte(8'($urandom_range(0, 255)));
      end
      if (flavor >= 80 && flavor < 85) begin
         push_byte($urandom_range(0, 1) ? 8'hE2 : 8'hC3);
         if ($urandom_range(0, 1)) push_byte(8'h84);
      end
      if ($urandom_range(0, 4) == 0) begin
         push_byte(8'h00);
         repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
      end
      push_end(8'($urandom_range(0, 255)));
   endtask

   initial begin
      clear_decoder();
      // mapped two- and three-byte characters, table extremes
      push_byte(8'hC3); push_byte(8'h84);
      push_byte(8'hE2); push_byte(8'h84); push_byte(8'hA2);
      push_byte(8'hEF); push_byte(8'hA3); push_byte(8'hBF);
      push_byte(8'hCB); push_byte(8'h87); push_end(8'h00);
      // overlong zero and overlong ASCII, then terminator with trailing bytes
      push_byte(8'hC0); push_byte(8'h80); push_byte(8'h41);
      push_byte(8'hE0); push_byte(8'h81); push_byte(8'h81);
      push_byte(8'h7F); push_byte(8'h00); push_byte(8'hFF); push_end(8'hFF);
      // stray continuation, four-byte lead, zero as continuation
      push_byte(8'h80); push_end(8'h55);
      push_byte(8'hF0); push_end(8'hAA);
      push_byte(8'hC3); push_byte(8'h00); push_end(8'h00);
      // one character too many
      push_byte(8'h41); push_byte(8'h42); push_byte(8'h43);
      push_byte(8'h44); push_byte(8'h45); push_end(8'h00);
      // unmapped point, sequence left open, empty text
      push_byte(8'hC2); push_byte(8'h80); push_end(8'h00);
      push_byte(8'hE2); push_byte(8'h84); push_end(8'h00);
      push_end(8'hFF);
      while (utf8_beats.size() < RANDOM_BEATS) add_random_text();
      total_beats = utf8_beats.size();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (beats_accepted < total_beats) @(posedge clock);
      while (fourcc_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // sender: advance on a taken beat, otherwise hold the payload
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (utf8_beats.size() > 0) begin
            next_beat = utf8_beats.pop_front();
            req_text_byte   <= next_beat.text_byte;
            req_end_of_text <= next_beat.end_of_text;
            req_valid       <= 1'b1;
            send_gap        <= quiet ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         decode_utf8_beat(req_text_byte, req_end_of_text);
         beats_accepted <= beats_accepted + 1;
      end
   end

   // receiver: one long hold-off once traffic is flowing, random stalls otherwise
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && beats_accepted >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall  <= 1'b0;
            stall_left <= quiet ? 0 : pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fourcc_expected.size() == 0) begin
            report_mismatch("result beat with nothing pending", rsp_type_code, '0);
         end else begin
            fourcc_seen = fourcc_expected.pop_front();
            if (rsp_type_code !== fourcc_seen.type_code)
               report_mismatch("type_code", rsp_type_code, fourcc_seen.type_code);
            if (rsp_status !== fourcc_seen.status)
               report_mismatch("status", {31'h0, rsp_status}, {31'h0, fourcc_seen.status});
         end
      end
   end

endmodule
